// ===== design/gfic_pkg.sv =====
// gfic_pkg: opcodes and the pipeline word shared by the fp32/integer conversion stages.
// No dependencies.
`default_nettype none

package gfic_pkg;

    typedef enum logic [3:0] {
        OP_U32_F32 = 4'd0,
        OP_I32_F32 = 4'd1,
        OP_RPI     = 4'd2,
        OP_FLR     = 4'd3,
        OP_F32_U32 = 4'd4,
        OP_F32_I32 = 4'd5,
        OP_UBYTE0  = 4'd6,
        OP_UBYTE1  = 4'd7,
        OP_UBYTE2  = 4'd8,
        OP_UBYTE3  = 4'd9,
        OP_FREXP   = 4'd10,
        OP_OFF_I4  = 4'd11,
        OP_PK_U8   = 4'd12
    } op_t;

    localparam int SUM_W = 58;   // rpi fixed point sum, 25 fraction bits

    // Word carried down the pipe; later stages fill in their own fields
    typedef struct packed {
        logic [3:0]       op;
        logic [31:0]      a;
        logic [1:0]       bsel;
        logic [31:0]      c;
        logic [32:0]      mag;     // truncated |a|, capped at 2^32
        logic             frac;    // fraction dropped by truncation
        logic [31:0]      v;       // integer to normalize
        logic             ineg;    // sign of the integer
        logic [SUM_W-1:0] s;       // rpi sum, later rounded to 24 bits
        logic             sneg;    // rpi sum is negative
        logic [5:0]       p;       // msb index
        logic [7:0]       exb;     // biased exponent of the int conversion
        logic [22:0]      frac23;  // rounded fraction
    } pipe_t;

endpackage

`default_nettype wire

// ===== design/gfic_unpack.sv =====
// gfic_unpack: stage 1, field decode, truncation shift and rpi half add.
// Depends on gfic_pkg.
`default_nettype none

module gfic_unpack (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire logic [3:0]    req_type,
    input  wire logic [31:0]   src_a,
    input  wire logic [31:0]   src_b,
    input  wire logic [31:0]   src_c,
    output logic               valid_reg,
    output gfic_pkg::pipe_t    data_reg
);
    import gfic_pkg::*;

    localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << 24;

    pipe_t             data_next;
    logic [7:0]        e;
    logic [23:0]       mant;
    logic [7:0]        k;
    logic [7:0]        sh;
    logic [55:0]       prod;
    logic [SUM_W-1:0]  x;
    logic [3:0]        nib;

    always_comb
    begin
        e    = src_a[30:23];
        mant = {1'b1, src_a[22:0]};
        k    = e - 8'd127;
        sh   = e - 8'd125;
        prod = {32'b0, mant} << k[4:0];
        nib  = src_a[3:0];

        data_next        = '0;
        data_next.op     = req_type;
        data_next.a      = src_a;
        data_next.bsel   = src_b[1:0];
        data_next.c      = src_c;

        // truncated magnitude
        if (e < 8'd127)
        begin
            data_next.mag  = '0;
            data_next.frac = (src_a[30:0] != 31'd0);
        end
        else if (e >= 8'd159)
        begin
            data_next.mag  = 33'h1_0000_0000;
            data_next.frac = 1'b0;
        end
        else
        begin
            data_next.mag  = prod[55:23];
            data_next.frac = (prod[22:0] != 23'd0);
        end

        // integer source for normalization
        case (op_t'(req_type))
            OP_F32_U32: data_next.v = src_a;
            OP_F32_I32:
            begin
                data_next.ineg = src_a[31];
                data_next.v    = src_a[31] ? (32'd0 - src_a) : src_a;
            end
            OP_UBYTE0:  data_next.v = {24'b0, src_a[7:0]};
            OP_UBYTE1:  data_next.v = {24'b0, src_a[15:8]};
            OP_UBYTE2:  data_next.v = {24'b0, src_a[23:16]};
            OP_UBYTE3:  data_next.v = {24'b0, src_a[31:24]};
            OP_FREXP:   data_next.v = {9'b0, src_a[22:0]};
            OP_OFF_I4:
            begin
                data_next.ineg = nib[3];
                data_next.v    = {28'b0, nib[3] ? (4'd0 - nib) : nib};
            end
            default:    data_next.v = '0;
        endcase

        // rpi: a + 0.5 in fixed point, as sign and magnitude
        x = '0;
        if (e >= 8'd125 && e <= 8'd157)
            x = {34'b0, mant} << sh[5:0];
        if (!src_a[31])
            data_next.s = x + HALF;
        else if (x >= HALF)
        begin
            data_next.s    = x - HALF;
            data_next.sneg = 1'b1;
        end
        else
            data_next.s = HALF - x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/gfic_msb.sv =====
// gfic_msb: stage 2, leading one search over the integer or the rpi sum.
// Depends on gfic_pkg.
`default_nettype none

module gfic_msb (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire gfic_pkg::pipe_t data_in,
    output logic               valid_reg,
    output gfic_pkg::pipe_t    data_reg
);
    import gfic_pkg::*;

    pipe_t             data_next;
    logic [SUM_W-1:0]  w;

    // priority encoder, highest set bit wins
    always_comb
    begin
        data_next = data_in;
        w = (op_t'(data_in.op) == OP_RPI) ? data_in.s : {26'b0, data_in.v};
        data_next.p = '0;
        for (int i = 0; i < SUM_W; i++)
        begin
            if (w[i])
                data_next.p = 6'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/gfic_round.sv =====
// gfic_round: stage 3, normalize and round to nearest even (int to fp32, rpi sum).
// Depends on gfic_pkg.
`default_nettype none

module gfic_round (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire gfic_pkg::pipe_t data_in,
    output logic               valid_reg,
    output gfic_pkg::pipe_t    data_reg
);
    import gfic_pkg::*;

    pipe_t             data_next;
    logic [31:0]       n;
    logic [7:0]        rem8;
    logic              inc;
    logic [24:0]       m1;
    logic [5:0]        dd;
    logic [SUM_W-1:0]  mask;
    logic [SUM_W-1:0]  hb;
    logic [SUM_W-1:0]  rem;
    logic              sinc;

    always_comb
    begin
        data_next = data_in;

        // integer path: msb to bit 31, round at bit 8
        n    = data_in.v << (5'd31 - data_in.p[4:0]);
        rem8 = n[7:0];
        inc  = (rem8 > 8'h80) || (rem8 == 8'h80 && n[8]);
        m1   = {1'b0, n[31:8]} + {24'b0, inc};
        data_next.exb    = {2'b0, data_in.p} + 8'd127 + {7'b0, m1[24]};
        data_next.frac23 = m1[24] ? 23'd0 : m1[22:0];

        // rpi path: keep 24 significant bits of the sum
        dd   = (data_in.p > 6'd23) ? (data_in.p - 6'd23) : 6'd0;
        mask = (SUM_W'(1) << dd) - SUM_W'(1);
        hb   = (SUM_W'(1) << dd) >> 1;
        rem  = data_in.s & mask;
        sinc = (dd != 6'd0) && ((rem > hb) || (rem == hb && data_in.s[dd]));
        data_next.s = (data_in.s & ~mask) + (sinc ? (SUM_W'(1) << dd) : SUM_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== design/gfic_pack.sv =====
// gfic_pack: stage 4, saturation, result assembly and opcode select into the output register.
// Depends on gfic_pkg.
`default_nettype none

module gfic_pack (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic          valid_in,
    input  wire gfic_pkg::pipe_t data_in,
    output logic               valid_reg,
    output logic [31:0]        result_reg
);
    import gfic_pkg::*;

    function automatic logic [31:0] sat_i32(input logic [33:0] m, input logic neg);
        logic big;
        big = (m >= 34'h0_8000_0000);
        if (!neg)
            sat_i32 = big ? 32'h7fff_ffff : m[31:0];
        else
            sat_i32 = big ? 32'h8000_0000 : (32'd0 - m[31:0]);
    endfunction

    logic [31:0]       result_next;
    logic [7:0]        e;
    logic              nan;
    logic              sgn;
    logic [33:0]       imag;
    logic [7:0]        ubyte;
    logic [SUM_W-1:0]  t;
    logic [31:0]       fp;
    logic [31:0]       bmask;
    logic [4:0]        bsh;

    always_comb
    begin
        e     = data_in.a[30:23];
        nan   = (e == 8'hff) && (data_in.a[22:0] != 23'd0);
        sgn   = data_in.a[31];
        imag  = {1'b0, data_in.mag} +
                {33'b0, (op_t'(data_in.op) == OP_FLR) && sgn && data_in.frac};
        ubyte = (nan || sgn) ? 8'd0 :
                (data_in.mag >= 33'd255) ? 8'hff : data_in.mag[7:0];
        t     = data_in.sneg ? (data_in.s + SUM_W'(33554431)) : data_in.s;
        fp    = {data_in.ineg, data_in.exb, data_in.frac23};
        bsh   = {data_in.bsel, 3'b0};
        bmask = 32'h0000_00ff << bsh;

        case (op_t'(data_in.op))
            OP_U32_F32:
                result_next = (nan || sgn) ? 32'd0 :
                              (data_in.mag >= 33'h0_ffff_ffff) ? 32'hffff_ffff :
                              data_in.mag[31:0];
            OP_I32_F32, OP_FLR:
                result_next = nan ? 32'd0 : sat_i32(imag, sgn);
            OP_RPI:
            begin
                if (nan || e <= 8'd124 || data_in.s == '0)
                    result_next = 32'd0;
                else if (e >= 8'd158)
                    result_next = sgn ? 32'h8000_0000 : 32'h7fff_ffff;
                else
                    result_next = sat_i32({1'b0, t[57:25]}, data_in.sneg);
            end
            OP_F32_U32, OP_F32_I32, OP_UBYTE0, OP_UBYTE1, OP_UBYTE2, OP_UBYTE3:
                result_next = (data_in.v == 32'd0) ? 32'd0 : fp;
            OP_OFF_I4:
                result_next = (data_in.v == 32'd0) ? 32'd0 :
                              {data_in.ineg, data_in.exb - 8'd4, data_in.frac23};
            OP_FREXP:
            begin
                if (e == 8'hff)
                    result_next = 32'd0;
                else if (e != 8'd0)
                    result_next = {24'b0, e} - 32'd126;
                else if (data_in.a[22:0] == 23'd0)
                    result_next = 32'd0;
                else
                    result_next = {26'b0, data_in.p} - 32'd148;
            end
            OP_PK_U8:
                result_next = (data_in.c & ~bmask) | ({24'b0, ubyte} << bsh);
            default:
                result_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

// ===== design/gpu_fp32_int_conversion_unit.sv =====
// gpu_fp32_int_conversion_unit: top level, four stage fp32/integer conversion pipe.
// Depends on gfic_pkg, gfic_unpack, gfic_msb, gfic_round, gfic_pack.
//
//  channel   valid      stall      payload
//  request   req_valid  req_stall  req_type, src_a, src_b, src_c
//  response  res_valid  res_stall  result
//
// One transfer per cycle sustained in both directions while no result is stalled.
// The four stage registers share one advance enable; the last stage is the output register.
// res_stall holds the whole pipe and raises req_stall only while a result waits.
// Reset clears the stage valid bits only.
`default_nettype none

module gpu_fp32_int_conversion_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [3:0]  req_type,
    input  wire logic [31:0] src_a,
    input  wire logic [31:0] src_b,
    input  wire logic [31:0] src_c,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [31:0]      result
);
    import gfic_pkg::*;

    logic  adv;
    logic  v1, v2, v3;
    pipe_t d1, d2, d3;

    // pipe moves unless a held result is stalled
    assign adv       = !(res_valid && res_stall);
    assign req_stall = !adv;

    gfic_unpack u_unpack (
        .clk(clk), .rst_n(rst_n), .adv(adv), .valid_in(req_valid),
        .req_type(req_type), .src_a(src_a), .src_b(src_b), .src_c(src_c),
        .valid_reg(v1), .data_reg(d1)
    );

    gfic_msb u_msb (
        .clk(clk), .rst_n(rst_n), .adv(adv), .valid_in(v1), .data_in(d1),
        .valid_reg(v2), .data_reg(d2)
    );

    gfic_round u_round (
        .clk(clk), .rst_n(rst_n), .adv(adv), .valid_in(v2), .data_in(d2),
        .valid_reg(v3), .data_reg(d3)
    );

    gfic_pack u_pack (
        .clk(clk), .rst_n(rst_n), .adv(adv), .valid_in(v3), .data_in(d3),
        .valid_reg(res_valid), .result_reg(result)
    );

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (v3 && adv) |=> res_valid)
        else $error("stage 3 item did not reach the output");

    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (!v3 && adv) |=> !res_valid)
        else $error("output valid without a source item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv) |=> (v1 == $past(v1) && v2 == $past(v2) && v3 == $past(v3)))
        else $error("pipe moved during a stall");

endmodule

`default_nettype wire
